### rtl/core/tte_pkg.sv
// Shared types and codes for the timer table with ordered expiry.
`timescale 1ns / 1ps
package tte_pkg;
	localparam logic [2:0] FUNC_TICK  = 3'd0;
	localparam logic [2:0] FUNC_START = 3'd1;
	localparam logic [2:0] FUNC_STOP  = 3'd2;
	localparam logic [2:0] FUNC_GET   = 3'd3;
	localparam logic [2:0] FUNC_SET   = 3'd4;

	localparam logic [2:0] KIND_STARTED = 3'd0;
	localparam logic [2:0] KIND_STOPPED = 3'd1;
	localparam logic [2:0] KIND_READ    = 3'd2;
	localparam logic [2:0] KIND_SET     = 3'd3;
	localparam logic [2:0] KIND_EXPIRED = 3'd4;
	localparam logic [2:0] KIND_DONE    = 3'd5;

	typedef struct packed {
		logic load;
		logic scan_clr;
		logic scan_step;
		logic apply;
		logic exp_step;
		logic emit;
		logic emit_expired;
		logic emit_done;
	} tte_cmd_t;

	typedef struct packed {
		logic scan_end;
		logic is_tick;
		logic func_ok;
		logic any_pending;
	} tte_sts_t;
endpackage

### rtl/core/timer_table_with_ordered_expiry_top.sv
// Top level of the timer table with ordered expiry.
// Start, stop, get, set: a scan over all timer slots, then an apply state that also emits the result.
// Tick: a scan that adds the tick delta to each live timer, then for each expired timer a selection pass over
// all slots and an emit, then the done item. Unknown codes: a scan only, no result.
// Results appear on valid in the cycle after emission; the receiver cannot stall.
// Reset clears all live flags and the id counter at once; no clearing pass.
`timescale 1ns / 1ps
module timer_table_with_ordered_expiry_top #(
	parameter int NUM_TIMERS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  func,
	input  logic [15:0] delta_ticks,
	input  logic [31:0] duration_ticks,
	input  logic [31:0] handle_id,
	input  logic [31:0] new_elapsed,
	output logic        valid,
	output logic [2:0]  kind,
	output logic [31:0] result_id,
	output logic [31:0] elapsed_out,
	output logic        found,
	output logic        last
);
	tte_pkg::tte_cmd_t cmd;
	tte_pkg::tte_sts_t sts;

	tte_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd), .sts(sts)
	);

	tte_dp #(.NUM_TIMERS(NUM_TIMERS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.func(func), .delta_ticks(delta_ticks), .duration_ticks(duration_ticks),
		.handle_id(handle_id), .new_elapsed(new_elapsed),
		.valid(valid), .kind(kind), .result_id(result_id),
		.elapsed_out(elapsed_out), .found(found), .last(last)
	);
endmodule

### rtl/core/tte_ctrl.sv
// Controller state machine for the timer table.
`timescale 1ns / 1ps
module tte_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output tte_pkg::tte_cmd_t cmd,
	input  tte_pkg::tte_sts_t sts
);
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SCAN  = 6'b000010,
		ST_APPLY = 6'b000100,
		ST_SEL   = 6'b001000,
		ST_EMIT  = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					cmd.scan_clr = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_end) begin
					if (!sts.func_ok) state_d = ST_IDLE;
					else if (sts.is_tick) state_d = ST_SEL;
					else state_d = ST_APPLY;
					cmd.scan_clr = 1'b1;
				end
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				cmd.emit = 1'b1;
				state_d = ST_IDLE;
			end
			ST_SEL: begin
				if (!sts.any_pending) begin
					state_d = ST_DONE;
				end else begin
					cmd.exp_step = 1'b1;
					if (sts.scan_end) state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				cmd.emit_expired = 1'b1;
				cmd.scan_clr = 1'b1;
				state_d = ST_SEL;
			end
			ST_DONE: begin
				cmd.emit = 1'b1;
				cmd.emit_done = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
endmodule

### rtl/core/tte_dp.sv
// Datapath: timer slot memory, scan index, expiry selection and result registers.
`timescale 1ns / 1ps
module tte_dp #(
	parameter int NUM_TIMERS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tte_pkg::tte_cmd_t cmd,
	output tte_pkg::tte_sts_t sts,
	input  logic [2:0]        func,
	input  logic [15:0]       delta_ticks,
	input  logic [31:0]       duration_ticks,
	input  logic [31:0]       handle_id,
	input  logic [31:0]       new_elapsed,
	output logic              valid,
	output logic [2:0]        kind,
	output logic [31:0]       result_id,
	output logic [31:0]       elapsed_out,
	output logic              found,
	output logic              last
);
	localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TIMERS - 1);

	logic [31:0] id_mem [NUM_TIMERS];
	logic [31:0] dur_mem [NUM_TIMERS];
	logic [31:0] el_mem [NUM_TIMERS];
	logic [NUM_TIMERS-1:0] live_q, pend_q;

	logic [2:0]  func_q;
	logic [15:0] delta_q;
	logic [31:0] dur_q, hid_q, nel_q, last_id_q;
	logic [IW-1:0] idx_q, hit_q, best_q;
	logic        hit_v_q, best_v_q;
	logic [31:0] best_over_q;

	logic [31:0] cur_id, cur_dur, cur_el, sum_el, over;
	logic [32:0] sum_w;
	logic        is_tick, func_ok, match, is_free;

	assign cur_id  = id_mem[idx_q];
	assign cur_dur = dur_mem[idx_q];
	assign cur_el  = el_mem[idx_q];
	assign sum_w   = {1'b0, cur_el} + {17'd0, delta_q};
	assign sum_el  = sum_w[32] ? 32'hFFFF_FFFF : sum_w[31:0];
	assign over    = cur_el - cur_dur;
	assign is_tick = (func_q == tte_pkg::FUNC_TICK);
	assign func_ok = (func_q <= tte_pkg::FUNC_SET);
	assign match   = live_q[idx_q] && (cur_id == hid_q);
	assign is_free = !live_q[idx_q];

	assign sts.scan_end    = (idx_q == LAST_IDX);
	assign sts.is_tick     = is_tick;
	assign sts.func_ok     = func_ok;
	assign sts.any_pending = |pend_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= func;
			delta_q <= delta_ticks;
			dur_q   <= duration_ticks;
			hid_q   <= handle_id;
			nel_q   <= new_elapsed;
		end
		if (cmd.scan_clr) idx_q <= '0;
		else if (cmd.scan_step || cmd.exp_step) idx_q <= idx_q + IW'(1);
		if (cmd.scan_step && is_tick && live_q[idx_q]) el_mem[idx_q] <= sum_el;
		if (cmd.apply && func_q == tte_pkg::FUNC_START && hit_v_q) begin
			id_mem[hit_q]  <= last_id_q + 32'd1;
			dur_mem[hit_q] <= dur_q;
			el_mem[hit_q]  <= '0;
		end
		if (cmd.apply && func_q == tte_pkg::FUNC_SET && hit_v_q) el_mem[hit_q] <= nel_q;
		if (cmd.load) begin
			hit_v_q <= 1'b0;
		end else if (cmd.scan_step && !hit_v_q) begin
			if ((func_q == tte_pkg::FUNC_START) ? is_free : match) begin
				hit_v_q <= 1'b1;
				hit_q   <= idx_q;
			end
		end
		if (cmd.scan_clr) best_v_q <= 1'b0;
		else if (cmd.exp_step && pend_q[idx_q] && (!best_v_q || over > best_over_q)) begin
			best_v_q    <= 1'b1;
			best_q      <= idx_q;
			best_over_q <= over;
		end
		if (cmd.emit) begin
			priority if (cmd.emit_expired) begin
				kind        <= tte_pkg::KIND_EXPIRED;
				result_id   <= id_mem[best_q];
				elapsed_out <= el_mem[best_q];
				found       <= 1'b1;
				last        <= 1'b0;
			end else if (cmd.emit_done) begin
				kind        <= tte_pkg::KIND_DONE;
				result_id   <= '0;
				elapsed_out <= '0;
				found       <= 1'b0;
				last        <= 1'b1;
			end else begin
				found <= hit_v_q;
				last  <= 1'b1;
				unique case (func_q)
					tte_pkg::FUNC_START: begin
						kind        <= tte_pkg::KIND_STARTED;
						result_id   <= hit_v_q ? last_id_q + 32'd1 : '0;
						elapsed_out <= '0;
					end
					tte_pkg::FUNC_STOP: begin
						kind        <= tte_pkg::KIND_STOPPED;
						result_id   <= hid_q;
						elapsed_out <= '0;
					end
					tte_pkg::FUNC_GET: begin
						kind        <= tte_pkg::KIND_READ;
						result_id   <= hid_q;
						elapsed_out <= hit_v_q ? el_mem[hit_q] : '0;
					end
					default: begin
						kind        <= tte_pkg::KIND_SET;
						result_id   <= hid_q;
						elapsed_out <= '0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q    <= '0;
			pend_q    <= '0;
			last_id_q <= '0;
			valid     <= 1'b0;
		end else begin
			valid <= cmd.emit;
			if (cmd.scan_step && is_tick && live_q[idx_q])
				pend_q[idx_q] <= (sum_el >= cur_dur);
			if (cmd.apply && hit_v_q) begin
				if (func_q == tte_pkg::FUNC_START) begin
					live_q[hit_q] <= 1'b1;
					last_id_q <= last_id_q + 32'd1;
				end else if (func_q == tte_pkg::FUNC_STOP) begin
					live_q[hit_q] <= 1'b0;
				end
			end
			if (cmd.emit_expired) begin
				live_q[best_q] <= 1'b0;
				pend_q[best_q] <= 1'b0;
			end
		end
	end
endmodule

### rtl/core/tte_checker.sv
// Port-level checker for the timer table, bound to the top level.
`timescale 1ns / 1ps
module tte_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        valid,
	input logic [2:0]  kind,
	input logic        found,
	input logic        last
);
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted transfer did not raise busy");
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (kind <= tte_pkg::KIND_DONE)) else $error("bad result kind");
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (last == (kind != tte_pkg::KIND_EXPIRED)))
		else $error("last flag disagrees with kind");
	a_done_found: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && (kind == tte_pkg::KIND_DONE || kind == tte_pkg::KIND_EXPIRED))
		|-> (found == (kind == tte_pkg::KIND_EXPIRED))) else $error("found flag wrong");
	a_no_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && !$past(busy)) |-> !valid) else $error("result while idle");
endmodule

bind timer_table_with_ordered_expiry_top tte_checker u_tte_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .valid(valid),
	.kind(kind), .found(found), .last(last)
);
